[hdl/jps_pkg.sv]
// Shared types, constants and fixed-point helpers for the 1D Jacobi Poisson solver.
// No dependencies; imported by every module of the block.
package jps_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 48;
  localparam int IDX_W          = 10;
  localparam int CFG_W          = 47;
  localparam int CFG_IDX_W      = 3;
  localparam int ITER_W         = 24;
  localparam int NC_W           = 11;
  localparam int MODE_W         = 2;
  localparam int MUL_A_W        = 64;
  localparam int MUL_B_W        = 48;
  localparam int PROD_W         = 112;

  localparam logic [NC_W-1:0]   NODE_COUNT_RST = NC_W'(33);
  localparam logic [CFG_W-1:0]  H_SQUARED_RST  = CFG_W'(64'd4194304);
  localparam logic [CFG_W-1:0]  INV_H_SQ_RST   = CFG_W'(64'd4398046511104);
  localparam logic [CFG_W-1:0]  TOLERANCE_RST  = CFG_W'(64'd4295);
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST = ITER_W'(10000000);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_SOLVE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT = 3'd0,
    REG_H_SQUARED  = 3'd1,
    REG_INV_H_SQ   = 3'd2,
    REG_TOLERANCE  = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } reg_e;

  typedef struct packed {
    logic [NC_W-1:0]   node_count;
    logic [CFG_W-1:0]  h_squared;
    logic [CFG_W-1:0]  inv_h_squared;
    logic [CFG_W-1:0]  tolerance;
    logic [ITER_W-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // floor(+-prod / 2^32), magnitude capped at 2^62
  function automatic logic signed [63:0] mul_shift(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
    logic [63:0] q;
    q = (|prod[PROD_W-1:94]) ? 64'h4000_0000_0000_0000 : {2'b00, prod[93:32]};
    if (neg) begin
      q = q + 64'(|prod[31:0]);
      return -q;
    end
    return q;
  endfunction

endpackage

[hdl/jps_mul.sv]
// Shared multi-cycle multiplier: 64 x 48 unsigned product from four 32x32 beats.
// Depends on jps_pkg.
module jps_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jps_pkg::mul_req_t           req_i,
  output logic                        done_o,
  output logic [jps_pkg::PROD_W-1:0]  prod_o
);
  import jps_pkg::*;

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [PROD_W-1:0]  acc_q;
  logic [1:0]         step_q;
  logic               busy_q, done_q;
  logic [31:0]        a_part, b_part;
  logic [63:0]        pp;
  logic [PROD_W-1:0]  pp_sh;

  always_comb begin
    a_part = step_q[0] ? a_q[63:32] : a_q[31:0];
    b_part = step_q[1] ? {16'd0, b_q[47:32]} : b_q[31:0];
    pp     = a_part * b_part;
    pp_sh  = PROD_W'(pp) << (7'(step_q[0]) * 7'd32 + 7'(step_q[1]) * 7'd32);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hdl/jps_core.sv]
// Solver sequencer: node memories, sweep and residual passes, result register.
// Depends on jps_pkg and jps_mul.
module jps_core #(
  parameter int MAX_NODES  = jps_pkg::MAX_NODES_DEF,
  parameter int VALUE_BITS = jps_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jps_pkg::cfg_t                 cfg_i,
  input  logic                          go_i,
  input  jps_pkg::mode_e                mode_i,
  input  logic [jps_pkg::IDX_W-1:0]     idx_i,
  input  logic signed [VALUE_BITS-1:0]  rhs_i,
  input  logic signed [VALUE_BITS-1:0]  start_i,
  output logic                          idle_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic signed [VALUE_BITS-1:0]  res_value_o,
  output logic [jps_pkg::ITER_W-1:0]    res_iter_o,
  output logic                          res_conv_o
);
  import jps_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_TOL_SQ, ST_TOL_N, ST_PASS_INIT, ST_PASS_C, ST_NODE_RD,
    ST_NODE_GOT, ST_NODE_OP, ST_SW_MUL, ST_RS_MUL, ST_SQ, ST_SQ_MUL, ST_ADVANCE,
    ST_PASS_END
  } state_e;

  state_e state_q;

  logic signed [VALUE_BITS-1:0] rhs_mem [MAX_NODES];
  logic signed [VALUE_BITS-1:0] val_mem [MAX_NODES];
  logic signed [VALUE_BITS-1:0] vrd_q, rrd_q;

  logic signed [VALUE_BITS-1:0] ul_q, uc_q, ur_q, rh_q;
  logic signed [63:0]           r_q;
  logic [63:0]                  sum_q, lim_q;
  logic                         always_q, pass_res_q, neg_q;
  logic [CW-1:0]                j_q, n_q;
  logic [ITER_W-1:0]            iter_q;
  mul_req_t                     mul_q;
  logic                         mul_done;
  logic [PROD_W-1:0]            prod;

  logic                         res_valid_q, res_conv_q;
  logic signed [VALUE_BITS-1:0] res_value_q;
  logic [ITER_W-1:0]            res_iter_q;

  logic                         idx_ok;
  logic [AW-1:0]                idx_a, j_a, j1_a;
  logic                         v_re, v_we, r_re, r_we;
  logic [AW-1:0]                v_raddr, v_waddr;
  logic signed [VALUE_BITS-1:0] v_wdata;

  logic signed [63:0] ul64, uc64, ur64, rh64, op_s, ms, sw_t, sw_s, sw_v, rs_r, bnd_r;
  logic [63:0]        r_mag, op_mag, rh_mag;
  logic [64:0]        acc_sum;
  logic [ITER_W-1:0]  cnt_new, limit;
  logic [CW-1:0]      n_clamp;

  function automatic logic signed [63:0] sat_v(input logic signed [63:0] x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  jps_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  always_comb begin
    idx_ok  = 32'(idx_i) < 32'(MAX_NODES);
    idx_a   = AW'(idx_i);
    j_a     = AW'(j_q);
    j1_a    = AW'(j_q + CW'(1));
    ul64    = 64'(ul_q);
    uc64    = 64'(uc_q);
    ur64    = 64'(ur_q);
    rh64    = 64'(rh_q);
    op_s    = sat_sub64(sat_add64(uc64, uc64), sat_add64(ul64, ur64));
    op_mag  = mag64(op_s);
    rh_mag  = mag64(rh64);
    ms      = mul_shift(prod, neg_q);
    sw_t    = sat_v(ms);
    sw_s    = sat_add64(sat_add64(sw_t, ul64), ur64);
    sw_v    = sat_v(sw_s >>> 1);
    rs_r    = sat_sub64(ms, rh64);
    bnd_r   = sat_sub64(uc64, rh64);
    r_mag   = mag64(r_q);
    acc_sum = {1'b0, sum_q} + {1'b0, prod[63:0]};
    cnt_new = iter_q + ITER_W'(1);
    limit   = (cfg_i.iteration_limit == '0) ? ITER_W'(1) : cfg_i.iteration_limit;
    if (32'(cfg_i.node_count) < 32'd3)              n_clamp = CW'(3);
    else if (32'(cfg_i.node_count) > 32'(MAX_NODES)) n_clamp = CW'(MAX_NODES);
    else                                             n_clamp = CW'(cfg_i.node_count);

    // memory ports
    v_re    = (state_q == ST_PASS_INIT) || (state_q == ST_NODE_RD) ||
              (state_q == ST_IDLE && go_i && mode_i == MODE_READ && idx_ok);
    v_raddr = (state_q == ST_IDLE) ? idx_a : ((state_q == ST_PASS_INIT) ? '0 : j1_a);
    r_re    = (state_q == ST_NODE_RD);
    r_we    = (state_q == ST_IDLE && go_i && mode_i == MODE_WRITE && idx_ok);
    v_we    = r_we || (state_q == ST_SW_MUL && mul_done);
    v_waddr = (state_q == ST_IDLE) ? idx_a : j_a;
    v_wdata = (state_q == ST_IDLE) ? start_i : VALUE_BITS'(sw_v);
  end

  always_ff @(posedge clk_i) begin
    if (v_we) val_mem[v_waddr] <= v_wdata;
    if (v_re) vrd_q <= val_mem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) rhs_mem[idx_a] <= rhs_i;
    if (r_re) rrd_q <= rhs_mem[j_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_q       <= '0;
      res_valid_q <= 1'b0;
      res_value_q <= '0;
      res_iter_q  <= '0;
      res_conv_q  <= 1'b0;
      sum_q       <= '0;
      iter_q      <= '0;
      lim_q       <= '0;
      always_q    <= 1'b0;
      pass_res_q  <= 1'b0;
      neg_q       <= 1'b0;
      j_q         <= '0;
      n_q         <= CW'(3);
      ul_q        <= '0;
      uc_q        <= '0;
      ur_q        <= '0;
      rh_q        <= '0;
      r_q         <= '0;
    end else begin
      mul_q.start <= 1'b0;
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (go_i) begin
            res_value_q <= '0;
            res_iter_q  <= '0;
            res_conv_q  <= 1'b0;
            unique case (mode_i)
              MODE_READ: begin
                if (idx_ok) state_q <= ST_READ;
                else        res_valid_q <= 1'b1;
              end
              MODE_SOLVE: begin
                n_q        <= n_clamp;
                iter_q     <= '0;
                always_q   <= 1'b0;
                pass_res_q <= 1'b0;
                mul_q      <= '{start: 1'b1, a: 64'(cfg_i.tolerance),
                                b: 48'(cfg_i.tolerance)};
                state_q    <= ST_TOL_SQ;
              end
              default: res_valid_q <= 1'b1;
            endcase
          end
        end
        ST_READ: begin
          res_value_q <= vrd_q;
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_TOL_SQ: begin
          if (mul_done) begin
            if (|prod[PROD_W-1:64]) begin
              always_q <= 1'b1;
              state_q  <= ST_PASS_INIT;
            end else begin
              mul_q   <= '{start: 1'b1, a: prod[63:0], b: 48'(n_q)};
              state_q <= ST_TOL_N;
            end
          end
        end
        ST_TOL_N: begin
          if (mul_done) begin
            if (|prod[PROD_W-1:64]) always_q <= 1'b1;
            lim_q      <= prod[63:0];
            pass_res_q <= 1'b0;
            state_q    <= ST_PASS_INIT;
          end
        end
        ST_PASS_INIT: state_q <= ST_PASS_C;
        ST_PASS_C: begin
          uc_q    <= vrd_q;
          j_q     <= '0;
          state_q <= ST_NODE_RD;
        end
        ST_NODE_RD: state_q <= ST_NODE_GOT;
        ST_NODE_GOT: begin
          ur_q    <= vrd_q;
          rh_q    <= rrd_q;
          state_q <= ST_NODE_OP;
        end
        ST_NODE_OP: begin
          if (j_q == '0 || j_q == n_q - CW'(1)) begin
            // boundary node: untouched by the sweep, plain difference in the residual
            r_q     <= bnd_r;
            state_q <= pass_res_q ? ST_SQ : ST_ADVANCE;
          end else if (!pass_res_q) begin
            neg_q   <= rh_q[VALUE_BITS-1];
            mul_q   <= '{start: 1'b1, a: rh_mag, b: 48'(cfg_i.h_squared)};
            state_q <= ST_SW_MUL;
          end else begin
            neg_q   <= op_s[63];
            mul_q   <= '{start: 1'b1, a: op_mag, b: 48'(cfg_i.inv_h_squared)};
            state_q <= ST_RS_MUL;
          end
        end
        ST_SW_MUL: if (mul_done) state_q <= ST_ADVANCE;
        ST_RS_MUL: begin
          if (mul_done) begin
            r_q     <= rs_r;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (|r_mag[63:32]) begin
            sum_q   <= '1;
            state_q <= ST_ADVANCE;
          end else begin
            mul_q   <= '{start: 1'b1, a: r_mag, b: 48'(r_mag[31:0])};
            state_q <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: begin
          if (mul_done) begin
            sum_q   <= acc_sum[64] ? '1 : acc_sum[63:0];
            state_q <= ST_ADVANCE;
          end
        end
        ST_ADVANCE: begin
          ul_q <= uc_q;
          uc_q <= ur_q;
          if (j_q == n_q - CW'(1)) begin
            state_q <= ST_PASS_END;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= ST_NODE_RD;
          end
        end
        ST_PASS_END: begin
          if (!pass_res_q) begin
            pass_res_q <= 1'b1;
            sum_q      <= '0;
            state_q    <= ST_PASS_INIT;
          end else begin
            iter_q <= cnt_new;
            if (always_q || sum_q <= lim_q || cnt_new >= limit) begin
              res_iter_q  <= cnt_new;
              res_conv_q  <= always_q || sum_q <= lim_q;
              res_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              pass_res_q <= 1'b0;
              state_q    <= ST_PASS_INIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_value_o = res_value_q;
  assign res_iter_o  = res_iter_q;
  assign res_conv_o  = res_conv_q;

endmodule

[hdl/jacobi_poisson_1d_solver.sv]
// Top level of the 1D Jacobi Poisson solver: stream ports, configuration registers.
// Depends on jps_pkg and jps_core.
//
// Usage: write beats (mode write) store a node's rhs and start value, read beats
// return a node value, and a solve beat runs Jacobi sweeps over node_count nodes
// until the summed squared residual is within tolerance^2 * node_count or the
// iteration limit is hit; every input beat yields exactly one output beat. A solve
// first forms tolerance^2 * node_count, then per sweep runs an update pass over the
// interior nodes and a residual pass over all nodes: every product goes through one
// shared multiplier that loads its operands and then sums four 32x32 partial
// products. The input side is not ready while a solve or read runs, or while a
// result is waiting and the output side stalls. Configuration may change only
// while the block is idle.
module jacobi_poisson_1d_solver #(
  parameter int MAX_NODES  = jps_pkg::MAX_NODES_DEF,
  parameter int VALUE_BITS = jps_pkg::VALUE_BITS_DEF,
  localparam int S_BITS    = jps_pkg::IDX_W + 2 * VALUE_BITS,
  localparam int S_DATA_W  = ((S_BITS + 7) / 8) * 8,
  localparam int M_BITS    = VALUE_BITS + jps_pkg::ITER_W + 1,
  localparam int M_DATA_W  = ((M_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jps_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // node_index, rhs_value, start_value, zero pad
  input  logic [S_DATA_W-1:0]               s_axis_tdata,
  // mode
  input  logic [jps_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // node_value, iteration_count, converged, zero pad
  output logic [M_DATA_W-1:0]               m_axis_tdata
);
  import jps_pkg::*;

  cfg_t cfg_q;
  logic idle, go, res_conv;
  logic signed [VALUE_BITS-1:0] res_value;
  logic [ITER_W-1:0] res_iter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count      <= NODE_COUNT_RST;
      cfg_q.h_squared       <= H_SQUARED_RST;
      cfg_q.inv_h_squared   <= INV_H_SQ_RST;
      cfg_q.tolerance       <= TOLERANCE_RST;
      cfg_q.iteration_limit <= ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_NODE_COUNT: cfg_q.node_count      <= cfg_data_i[NC_W-1:0];
        REG_H_SQUARED:  cfg_q.h_squared       <= cfg_data_i;
        REG_INV_H_SQ:   cfg_q.inv_h_squared   <= cfg_data_i;
        REG_TOLERANCE:  cfg_q.tolerance       <= cfg_data_i;
        REG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // one result slot: take a new beat while idle and the slot is free or drains this cycle
  assign s_axis_tready = idle && (!m_axis_tvalid || m_axis_tready);
  assign go            = s_axis_tvalid && s_axis_tready;

  jps_core #(
    .MAX_NODES  (MAX_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .go_i        (go),
    .mode_i      (mode_e'(s_axis_tuser)),
    .idx_i       (s_axis_tdata[IDX_W-1:0]),
    .rhs_i       (s_axis_tdata[IDX_W +: VALUE_BITS]),
    .start_i     (s_axis_tdata[IDX_W+VALUE_BITS +: VALUE_BITS]),
    .idle_o      (idle),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_value_o (res_value),
    .res_iter_o  (res_iter),
    .res_conv_o  (res_conv)
  );

  assign m_axis_tdata = M_DATA_W'({res_conv, res_iter, res_value});

endmodule

[tb/jacobi_poisson_1d_solver_test.sv]
// Self-checking testbench for jacobi_poisson_1d_solver: directed and random
// write/solve/read beats checked against a built-in Jacobi predictor.
// Depends on jps_pkg and the RTL of the block.
`timescale 1ns / 100ps

module jacobi_poisson_1d_solver_test;
  import jps_pkg::*;

  localparam int NODES     = 1024;
  localparam int S_DATA_W  = 112;
  localparam int M_DATA_W  = 80;
  localparam int WDOG_MAX  = 200000;
  localparam int HOLD_LEN  = 400;
  localparam int PRESS_PH  = 3;
  localparam longint V_HI  = 64'sd140737488355327;
  localparam longint V_LO  = -64'sd140737488355328;
  localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

  typedef struct {
    mode_e             mode;
    logic [9:0]        idx;
    logic signed [47:0] rhs;
    logic signed [47:0] start;
  } node_op_t;

  typedef struct {
    logic signed [47:0] node_value;
    logic [23:0]        iter_cnt;
    logic               conv;
  } solve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  jacobi_poisson_1d_solver i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and node stores
  // ---------------------------------------------------------------------------
  logic [10:0]  sh_nc    = 11'd33;
  logic [46:0]  sh_h2    = H_SQUARED_RST;
  logic [46:0]  sh_inv   = INV_H_SQ_RST;
  logic [46:0]  sh_tol   = TOLERANCE_RST;
  logic [23:0]  sh_limit = ITER_LIMIT_RST;
  logic signed [63:0] rhs_mem [NODES];
  logic signed [63:0] val_mem [NODES];
  logic signed [63:0] old_mem [NODES];

  solve_res_t pending_res_q[$];
  node_op_t   op_q[$];
  int errs = 0;

  // floor(a*b / 2^32), magnitude capped at 2^62
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic [63:0] b);
    logic [63:0]  m;
    logic [127:0] p;
    logic [63:0]  q;
    m = a[63] ? (~a + 64'd1) : a;
    p = {64'd0, m} * {64'd0, b};
    q = (|p[127:94]) ? 64'h4000_0000_0000_0000 : {2'b00, p[93:32]};
    if (a[63]) begin
      q = q + 64'(|p[31:0]);
      return -q;
    end
    return q;
  endfunction

  function automatic logic signed [63:0] sat48(input logic signed [63:0] x);
    if (x > V_HI) return V_HI;
    if (x < V_LO) return V_LO;
    return x;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic int eff_nodes();
    if (sh_nc < 3) return 3;
    if (sh_nc > NODES) return NODES;
    return sh_nc;
  endfunction

  // Sweeps until the squared residual sum fits tol^2*n or the limit is hit
  function automatic solve_res_t run_jacobi();
    solve_res_t r;
    int n;
    logic [23:0] lim, cnt;
    logic signed [63:0] t, s, res;
    logic [63:0] mg, sq, rsum, lim_lo;
    logic [64:0] acc;
    logic [127:0] t2, p;
    logic done;
    n = eff_nodes();
    lim = (sh_limit == 0) ? 24'd1 : sh_limit;
    cnt = '0;
    r = '{default: '0};
    done = 1'b0;
    while (!done) begin
      for (int j = 0; j < n; j++) old_mem[j] = val_mem[j];
      for (int j = 1; j + 1 < n; j++) begin
        t = sat48(fx_mul(rhs_mem[j], 64'(sh_h2)));
        s = sadd(sadd(t, old_mem[j-1]), old_mem[j+1]);
        val_mem[j] = sat48(s >>> 1);
      end
      rsum = '0;
      for (int j = 0; j < n; j++) begin
        if (j == 0 || j + 1 == n) res = ssub(val_mem[j], rhs_mem[j]);
        else begin
          s = ssub(sadd(val_mem[j], val_mem[j]), sadd(val_mem[j-1], val_mem[j+1]));
          res = ssub(fx_mul(s, 64'(sh_inv)), rhs_mem[j]);
        end
        mg = res[63] ? (~res + 64'd1) : res;
        sq = (mg > 64'hFFFF_FFFF) ? '1 : mg * mg;
        acc = {1'b0, rsum} + {1'b0, sq};
        rsum = acc[64] ? '1 : acc[63:0];
      end
      cnt = cnt + 24'd1;
      t2 = {64'd0, 17'd0, sh_tol} * {64'd0, 17'd0, sh_tol};
      p = {64'd0, t2[63:0]} * 128'(n);
      lim_lo = p[63:0];
      if (t2[127:64] != 0 || p[127:64] != 0 || rsum <= lim_lo) begin
        r.conv = 1'b1;
        done = 1'b1;
      end else if (cnt >= lim) done = 1'b1;
    end
    r.iter_cnt = cnt;
    return r;
  endfunction

  function automatic solve_res_t predict_beat(input node_op_t op);
    solve_res_t r;
    r = '{default: '0};
    case (op.mode)
      MODE_WRITE: begin
        rhs_mem[op.idx] = 64'(op.rhs);
        val_mem[op.idx] = 64'(op.start);
      end
      MODE_SOLVE: r = run_jacobi();
      MODE_READ:  r.node_value = val_mem[op.idx][47:0];
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor, watchdog
  // ---------------------------------------------------------------------------
  int snd_idle = 0;
  int rcv_stall = 0;
  int phase = 0;
  node_op_t cur_op;
  int hold_cnt = 0;
  bit held = 0;
  int wdog = 0;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      pending_res_q.push_back(predict_beat(cur_op));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (op_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        cur_op = op_q.pop_front();
        s_axis_tdata  <= {6'd0, cur_op.start, cur_op.rhs, cur_op.idx};
        s_axis_tuser  <= cur_op.mode;
        s_axis_tvalid <= 1'b1;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off in the pressure phase
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (phase == PRESS_PH && !held) begin
      held <= 1'b1;
      hold_cnt <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk_i) begin
    solve_res_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_res_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errs++;
      end else begin
        e = pending_res_q.pop_front();
        if (m_axis_tdata[47:0] !== e.node_value) begin
          $error("node_value: expected %0d, got %0d", e.node_value,
                 $signed(m_axis_tdata[47:0]));
          errs++;
        end
        if (m_axis_tdata[71:48] !== e.iter_cnt) begin
          $error("iteration_count: expected %0d, got %0d", e.iter_cnt,
                 m_axis_tdata[71:48]);
          errs++;
        end
        if (m_axis_tdata[72] !== e.conv) begin
          $error("converged: expected %0b, got %0b", e.conv, m_axis_tdata[72]);
          errs++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit   written [NODES];
  int   written_list[$];

  function automatic logic signed [47:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return '0;
      1: return 48'($signed(r[35:0]));           // small, either sign
      2: return 48'($signed(r[20:0]));
      3: case ($urandom_range(3))
           0: return V_HI[47:0];
           1: return V_LO[47:0];
           2: return 48'sd1;
           default: return -48'sd1;
         endcase
      default: return r[47:0];
    endcase
  endfunction

  task automatic add_op(input mode_e m, input int idx,
                        input logic signed [47:0] rhs, input logic signed [47:0] st);
    node_op_t op;
    op.mode = m;
    op.idx = idx[9:0];
    op.rhs = rhs;
    op.start = st;
    if (m == MODE_WRITE && !written[idx]) begin
      written[idx] = 1;
      written_list.push_back(idx);
    end
    op_q.push_back(op);
  endtask

  // A solve touches nodes 0..n-1, so all of them must hold a written value
  task automatic add_solve();
    int n;
    n = eff_nodes();
    for (int j = 0; j < n; j++)
      if (!written[j]) add_op(MODE_WRITE, j, pick_value(), pick_value());
    add_op(MODE_SOLVE, $urandom_range(NODES-1), pick_value(), pick_value());
  endtask

  task automatic add_random(input int count, input int solve_pct);
    int r, n;
    n = eff_nodes();
    repeat (count) begin
      r = $urandom_range(99);
      if (r < solve_pct) add_solve();
      else if (r < 50)
        add_op(MODE_WRITE, ($urandom_range(9) < 7) ? $urandom_range(n-1) :
               $urandom_range(NODES-1), pick_value(), pick_value());
      else if (r < 92 && written_list.size() > 0)
        add_op(MODE_READ, written_list[$urandom_range(written_list.size()-1)],
               pick_value(), pick_value());
      else add_op(MODE_NOP, $urandom_range(NODES-1), pick_value(), pick_value());
    end
  endtask

  task automatic drain();
    while (op_q.size() > 0 || s_axis_tvalid || pending_res_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [10:0] nc, input logic [46:0] h2,
                          input logic [46:0] inv, input logic [46:0] tol,
                          input logic [23:0] lim);
    logic [46:0] vals [5];
    reg_e ids [5];
    vals = '{47'(nc), h2, inv, tol, 47'(lim)};
    ids  = '{REG_NODE_COUNT, REG_H_SQUARED, REG_INV_H_SQ, REG_TOLERANCE, REG_ITER_LIMIT};
    for (int k = 0; k < 5; k++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= ids[k];
      cfg_data_i  <= vals[k];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_nc = nc; sh_h2 = h2; sh_inv = inv; sh_tol = tol; sh_limit = lim;
  endtask

  function automatic logic [46:0] pick_tol();
    case ($urandom_range(3))
      0: return '0;
      1: return 47'($urandom_range(1 << 20));
      2: return CFG_MAX;
      default: return 47'({$urandom, $urandom});
    endcase
  endfunction

  initial begin
    logic [46:0] tol;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: plain writes, reads and idle beats, no solves
    add_op(MODE_WRITE, 0, V_HI[47:0], V_LO[47:0]);
    add_op(MODE_WRITE, 1023, V_LO[47:0], V_HI[47:0]);
    add_op(MODE_WRITE, 1, 48'sd0, 48'sd0);
    add_op(MODE_WRITE, 2, -48'sd1, 48'sd1);
    add_op(MODE_READ, 0, '0, '0);
    add_op(MODE_READ, 1023, '1, '1);
    add_op(MODE_READ, 2, '0, '0);
    add_op(MODE_NOP, 1023, '1, '1);
    add_op(MODE_NOP, 0, '0, '0);
    drain();

    // Smallest grid, zero spacing, zero tolerance, limit zero acting as one
    phase = 1;
    set_regs(11'd3, '0, '0, '0, '0);
    add_solve();
    add_op(MODE_READ, 1, '0, '0);
    add_op(MODE_WRITE, 1, V_HI[47:0], V_HI[47:0]);
    add_solve();
    add_op(MODE_READ, 1, '0, '0);
    drain();

    // Node count zero clamps to three, all-ones spacing registers
    phase = 2;
    set_regs(11'd0, CFG_MAX, CFG_MAX, 47'd4295, 24'd5);
    add_solve();
    add_op(MODE_READ, 1, '0, '0);
    add_op(MODE_WRITE, 0, '0, '0);
    add_op(MODE_WRITE, 1, '0, '0);
    add_op(MODE_WRITE, 2, '0, '0);
    add_solve();                                  // all zero: converges at once
    drain();

    // Random phases with small grids and short iteration limits
    for (int p = 3; p < 11; p++) begin
      phase = p;
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 68; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 68; end
        default: begin snd_idle = 22; rcv_stall = 22; end
      endcase
      if (p == PRESS_PH) begin snd_idle = 0; rcv_stall = 0; end
      tol = pick_tol();
      set_regs(11'($urandom_range(3, 10)),
               ($urandom_range(1)) ? 47'($urandom_range(1 << 24)) :
                                     47'({$urandom, $urandom}),
               ($urandom_range(1)) ? 47'($urandom) << 10 : 47'({$urandom, $urandom}),
               tol, 24'($urandom_range(1, 8)));
      add_random(30, 6);
      drain();
    end

    // Large grid: node count above range clamps to the full store, one sweep
    phase = 11;
    snd_idle = 22; rcv_stall = 22;
    set_regs(11'h7FF, 47'($urandom), 47'($urandom), 47'd4295, 24'd1);
    add_solve();
    add_random(20, 0);
    drain();

    // Full store, largest limit, all-ones tolerance ends after one sweep
    phase = 12;
    set_regs(11'd1024, 47'($urandom), 47'({$urandom, $urandom}), CFG_MAX, 24'hFFFFFF);
    add_solve();
    add_random(20, 0);
    drain();

    if (errs == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
